// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ----- hdl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the circular deque modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 8;

    // Operation codes.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     full_res;
        logic                     empty_res;
    } out_item_t;

    // Outcome of one operation, as decided at the transfer cycle.
    typedef struct packed {
        logic [1:0] status;
        logic       use_rd;
        logic       full;
        logic       empty;
    } step_info_t;

endpackage

// ----- hdl/cdq_mem.sv -----
// ----------------------------------------------------------------------------
// cdq_mem
// Simple dual-port synchronous store with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read register only changes on a read, so it holds while the
    // consumer waits.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/cdq_ptr.sv -----
// ----------------------------------------------------------------------------
// cdq_ptr
// Head, tail, count and capacity state with the per-operation update logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ptr #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                     step_en,
    input  logic [2:0]               operation,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    output cdq_pkg::step_info_t      info
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int EW        = (CNT_W > cdq_pkg::CAP_W) ? CNT_W : cdq_pkg::CAP_W;
    localparam int RESET_CAP = (128 > DEPTH) ? DEPTH : 128;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [PTR_W-1:0] last_reg, last_next;

    logic [EW-1:0] cap_ext;
    logic [EW-1:0] eff_cap;
    logic          is_push;
    logic          is_pop;
    logic          is_peek;
    logic          front;
    logic          is_empty;
    logic          is_full;

    // The written capacity is clamped here to the range one to DEPTH.
    always_comb
    begin
        cap_ext = (cfg_wr_data == '0) ? EW'(1) : EW'(cfg_wr_data);
        eff_cap = (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
        cap_next  = CNT_W'(eff_cap);
        last_next = PTR_W'(eff_cap - EW'(1));
    end

    assign is_push  = operation inside {cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR};
    assign is_pop   = operation inside {cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR};
    assign is_peek  = operation inside {cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_REAR};
    assign front    = operation inside {cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_POP_FRONT,
                                        cdq_pkg::OP_PEEK_FRONT};
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= cap_reg);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = front ? head_reg : tail_reg;
        info.status = cdq_pkg::ST_OK;
        info.use_rd = 1'b0;

        if (is_push)
        begin
            if (is_full)
            begin
                info.status = cdq_pkg::ST_OVERFLOW;
            end
            else
            begin
                wr_en      = step_en;
                count_next = count_reg + CNT_W'(1);
                if (is_empty)
                begin
                    head_next = '0;
                    tail_next = '0;
                    wr_addr   = '0;
                end
                else if (front)
                begin
                    head_next = (head_reg == '0) ? last_reg : head_reg - PTR_W'(1);
                    wr_addr   = head_next;
                end
                else
                begin
                    tail_next = (tail_reg >= last_reg) ? '0 : tail_reg + PTR_W'(1);
                    wr_addr   = tail_next;
                end
            end
        end
        else if (is_pop || is_peek)
        begin
            if (is_empty)
            begin
                info.status = cdq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                rd_en       = step_en;
                info.use_rd = 1'b1;
                if (is_pop)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (front)
                    begin
                        head_next = (head_reg >= last_reg) ? '0 : head_reg + PTR_W'(1);
                    end
                    else
                    begin
                        tail_next = (tail_reg == '0) ? last_reg : tail_reg - PTR_W'(1);
                    end
                end
            end
        end

        info.full  = (count_next >= cap_reg);
        info.empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CNT_W'(RESET_CAP);
            last_reg  <= PTR_W'(RESET_CAP - 1);
        end
        else if (cfg_wr_en)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cap_next;
            last_reg  <= last_next;
        end
        else if (step_en)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular store with a configurable capacity.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    in_item  (operation, value)
//   output    out_valid / out_stall  out_item (status, data, full_res, empty_res)
//   config    cfg_wr_en              cfg_wr_data (capacity)
//
// One operation is taken per clock cycle while in_stall is low; its result
// passes through the registered store read and then the output register.
// Reset clears the pointers and the entry count and sets the capacity to 128
// (or DEPTH if smaller); the store itself is not cleared and needs no sweep.
// A stalled output holds its result while one more operation may enter; the
// input stalls only when both the read stage and the output register are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_deque #(
    parameter int DEPTH = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  cdq_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output cdq_pkg::out_item_t        out_item
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                        in_xfer;
    logic                        mem_wr_en;
    logic [PTR_W-1:0]            mem_wr_addr;
    logic                        mem_rd_en;
    logic [PTR_W-1:0]            mem_rd_addr;
    logic [cdq_pkg::DATA_W-1:0]  mem_rd_data;
    cdq_pkg::step_info_t         step_info;

    // Read stage: holds the outcome while the store read completes.
    logic                        a_valid_reg, a_valid_next;
    cdq_pkg::step_info_t         a_info_reg;
    logic                        a_move;

    // Output register.
    logic                        b_valid_reg, b_valid_next;
    cdq_pkg::out_item_t          b_item_reg;

    assign in_stall = a_valid_reg && b_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;
    assign a_move   = a_valid_reg && (!b_valid_reg || !out_stall);

    // Pointer and count state. All decisions for an operation are made here at
    // its transfer, so the next operation sees the updated pointers at once.
    cdq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (in_xfer),
        .operation   (in_item.operation),
        .wr_en       (mem_wr_en),
        .wr_addr     (mem_wr_addr),
        .rd_en       (mem_rd_en),
        .rd_addr     (mem_rd_addr),
        .info        (step_info)
    );

    // A push writes at its transfer edge, so a pop in the very next cycle
    // already reads the new value; no forwarding path is needed.
    cdq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (cdq_pkg::DATA_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (in_item.value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        a_valid_next = in_xfer || (a_valid_reg && !a_move);
        if (a_move)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_valid_reg && !out_stall)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Payload registers need no reset. The store read data stays put while
    // the read stage waits, because no new read is issued during that time.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_info_reg <= step_info;
        end
        if (a_move)
        begin
            b_item_reg.status    <= a_info_reg.status;
            b_item_reg.data      <= a_info_reg.use_rd ? mem_rd_data : '0;
            b_item_reg.full_res  <= a_info_reg.full;
            b_item_reg.empty_res <= a_info_reg.empty;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    // An overflow leaves the deque full, an underflow leaves it empty, and a
    // deque of capacity one or more is never both at once.
    `ASSERT_IMPLY(a_overflow_full, clk, rst_n,
        out_valid && (out_item.status == cdq_pkg::ST_OVERFLOW), out_item.full_res)
    `ASSERT_IMPLY(a_underflow_empty, clk, rst_n,
        out_valid && (out_item.status == cdq_pkg::ST_UNDERFLOW), out_item.empty_res)
    `ASSERT_NEVER(a_full_and_empty, clk, rst_n,
        out_valid && out_item.full_res && out_item.empty_res)

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_deque. Operations are queued in phases,
// one capacity setting per phase, and driven in random bursts. A behavioral
// mirror of the deque predicts every result. A monitor compares each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import cdq_pkg::*;

    localparam int DEPTH          = 128;
    localparam int PTR_W          = $clog2(DEPTH);
    localparam int RESET_CAPACITY = 128;
    // Margin that wait_idle adds once every result is back, before the bench
    // treats the pipeline as drained.
    localparam int PIPE_DRAIN     = 4;
    localparam int LONG_HOLD      = 90;
    localparam int WATCHDOG_LIMIT = 2000;

    // Operation codes that the block does not define. They must leave the
    // state alone and report the current flags.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;

    circular_deque #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Mirror of the deque. It is advanced once per accepted input transfer
    // and cleared whenever the capacity register is written.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] mirror_mem [DEPTH];
    int unsigned       mirror_head;
    int unsigned       mirror_tail;
    int unsigned       mirror_count;
    logic [CAP_W-1:0]  mirror_cap;

    in_item_t          op_backlog[$];
    out_item_t         predicted_results[$];

    // Transfer counters are updated with nonblocking assignments at the clock
    // edge, so the stimulus process can read them safely at the falling edge.
    int                accepted_count = 0;
    int                checked_count = 0;
    int                error_count = 0;
    int                quiet_cycles = 0;
    int                backpressure_cycles = 0;
    int                n_overflow = 0;
    int                n_underflow = 0;
    int                n_full = 0;
    int                n_settings = 0;

    bit                sender_hold = 1'b0;
    bit                long_hold_req = 1'b0;

    // A register value of zero behaves as one entry, anything above the
    // store depth saturates to the depth.
    function automatic int unsigned usable_slots();
        if (mirror_cap == 0)
            return 1;
        if (mirror_cap > DEPTH)
            return DEPTH;
        return 32'(mirror_cap);
    endfunction

    function automatic out_item_t deque_apply(in_item_t it);
        out_item_t   r;
        int unsigned lim;
        bit          from_front;
        lim = usable_slots();
        r = '0;
        r.status = ST_OK;
        case (it.operation)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (mirror_count >= lim)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    // The first entry always lands in slot zero.
                    if (mirror_count == 0)
                    begin
                        mirror_head = 0;
                        mirror_tail = 0;
                        mirror_mem[0] = it.value;
                    end
                    else if (it.operation == OP_PUSH_FRONT)
                    begin
                        mirror_head = (mirror_head == 0) ? lim - 1 : mirror_head - 1;
                        mirror_mem[PTR_W'(mirror_head)] = it.value;
                    end
                    else
                    begin
                        mirror_tail = (mirror_tail >= lim - 1) ? 0 : mirror_tail + 1;
                        mirror_mem[PTR_W'(mirror_tail)] = it.value;
                    end
                    mirror_count++;
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
            begin
                if (mirror_count == 0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    from_front = (it.operation == OP_POP_FRONT) ||
                                 (it.operation == OP_PEEK_FRONT);
                    r.data = mirror_mem[PTR_W'(from_front ? mirror_head : mirror_tail)];
                    if (it.operation == OP_POP_FRONT || it.operation == OP_POP_REAR)
                    begin
                        mirror_count--;
                        if (mirror_count == 0)
                        begin
                            mirror_head = 0;
                            mirror_tail = 0;
                        end
                        else if (from_front)
                        begin
                            mirror_head = (mirror_head >= lim - 1) ? 0 : mirror_head + 1;
                        end
                        else
                        begin
                            mirror_tail = (mirror_tail == 0) ? lim - 1 : mirror_tail - 1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.full_res  = (mirror_count >= lim);
        r.empty_res = (mirror_count == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Items come off the backlog in bursts of random length separated
    // by random gaps; a gap of zero is common, so long unbroken stretches
    // occur too. A presented item is held until its transfer completes.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        in_item_t  nxt_item;
        bit        nxt_valid;
        out_item_t want;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_item = in_item;
            if (in_valid && !in_stall)
            begin
                want = deque_apply(in_item);
                predicted_results.push_back(want);
                accepted_count <= accepted_count + 1;
                if (want.status == ST_OVERFLOW)
                    n_overflow++;
                if (want.status == ST_UNDERFLOW)
                    n_underflow++;
                if (want.full_res)
                    n_full++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (op_backlog.size() != 0 && !sender_hold)
                begin
                    nxt_item = op_backlog.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            // Exactly one nonblocking update per signal in this time step.
            in_valid <= nxt_valid;
            in_item <= nxt_item;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. The stall pattern is redrawn at regular intervals from no stall,
    // light and heavy random stalls, and a fixed one-in-four acceptance.
    // A long hold, requested by the stimulus, is counted down here.
    // ------------------------------------------------------------------------
    int unsigned rx_cycle;
    int          rx_mode;
    int          hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        bit nxt_stall;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_cycle = 0;
            rx_mode = 0;
            hold_left = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 50 == 0)
                rx_mode = $urandom_range(3);
            if (long_hold_req && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else
            begin
                case (rx_mode)
                    1: nxt_stall = ($urandom_range(99) < 30);
                    2: nxt_stall = ($urandom_range(99) < 70);
                    3: nxt_stall = (rx_cycle % 4 != 0);
                    default: nxt_stall = 1'b0;
                endcase
            end
            out_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. The result is captured at the edge of its transfer and checked
    // at the falling edge after it, once the driver has queued any prediction
    // made at that same edge.
    // ------------------------------------------------------------------------
    task automatic check_field(string field, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = out_item;
            checked_count <= checked_count + 1;
            @(negedge clk);
            if (predicted_results.size() == 0)
            begin
                $error("result transfer with no operation outstanding");
                error_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("status", DATA_W'(want.status), DATA_W'(got.status));
                check_field("data", want.data, got.data);
                check_field("full_res", DATA_W'(want.full_res), DATA_W'(got.full_res));
                check_field("empty_res", DATA_W'(want.empty_res),
                            DATA_W'(got.empty_res));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either channel for
    // too long. It also counts cycles in which the block held off the input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL circular_deque");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (in_valid && in_stall)
                backpressure_cycles <= backpressure_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_op(logic [2:0] op, logic [DATA_W-1:0] val);
        in_item_t it;
        it.operation = op;
        it.value = val;
        op_backlog.push_back(it);
    endtask

    // Waits at the falling edge until the backlog is empty, nothing is being
    // offered and every prediction has met its result.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (op_backlog.size() != 0 || in_valid || accepted_count != checked_count);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    // Only called while the block is idle. The write also empties the deque,
    // so the mirror is cleared with it.
    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        mirror_cap = v;
        mirror_head = 0;
        mirror_tail = 0;
        mirror_count = 0;
        n_settings++;
    endtask

    // Random operations in alternating fill and drain runs. Each run is a bit
    // longer than the capacity, so the deque reaches full and then empty and
    // overflows and underflows are hit repeatedly. Values are random with an
    // occasional extreme.
    task automatic add_random(int n);
        int                left;
        int                seg;
        int                k;
        int                pick;
        int unsigned       lim;
        bit                filling;
        logic [2:0]        op;
        logic [DATA_W-1:0] val;
        lim = usable_slots();
        filling = 1'b1;
        left = n;
        while (left > 0)
        begin
            seg = lim + lim / 4 + $urandom_range(2, 8);
            if (seg > left)
                seg = left;
            for (k = 0; k < seg; k++)
            begin
                pick = $urandom_range(99);
                if (filling)
                begin
                    if (pick < 92)
                        op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                    else if (pick < 97)
                        op = $urandom_range(1) ? OP_PEEK_REAR : OP_PEEK_FRONT;
                    else
                        op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
                end
                else
                begin
                    if (pick < 85)
                        op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
                    else if (pick < 93)
                        op = $urandom_range(1) ? OP_PEEK_REAR : OP_PEEK_FRONT;
                    else if (pick < 98)
                        op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                    else
                        op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
                end
                case ($urandom_range(15))
                    0: val = 32'h0000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = 32'h8000_0000;
                    3: val = 32'hFFFF_FFFF;
                    default: val = $urandom();
                endcase
                add_op(op, val);
            end
            left -= seg;
            filling = !filling;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        mirror_cap = CAP_W'(RESET_CAPACITY);
        mirror_head = 0;
        mirror_tail = 0;
        mirror_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, at the reset capacity: every operation on an empty deque,
        // then the extreme values through both ends, the spare codes with the
        // deque empty and not empty, and a push to the front of an empty
        // deque.
        add_op(OP_POP_FRONT, 32'h0);
        add_op(OP_POP_REAR, 32'hFFFF_FFFF);
        add_op(OP_PEEK_FRONT, 32'h0);
        add_op(OP_PEEK_REAR, 32'h0);
        add_op(OP_SPARE_LO, 32'hFFFF_FFFF);
        add_op(OP_PUSH_REAR, 32'h7FFF_FFFF);
        add_op(OP_PUSH_FRONT, 32'h8000_0000);
        add_op(OP_PUSH_REAR, 32'h0);
        add_op(OP_PEEK_FRONT, 32'h0);
        add_op(OP_PEEK_REAR, 32'h0);
        add_op(OP_SPARE_HI, 32'h5A5A_A5A5);
        add_op(OP_POP_REAR, 32'h0);
        add_op(OP_POP_FRONT, 32'h0);
        add_op(OP_POP_FRONT, 32'h0);
        add_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        add_op(OP_POP_REAR, 32'h0);
        wait_idle();

        // A single entry: full after one push, overflow from either end.
        set_capacity(8'd1);
        add_op(OP_PUSH_FRONT, 32'h0000_0001);
        add_op(OP_PUSH_REAR, 32'h0000_0002);
        add_op(OP_PUSH_FRONT, 32'h0000_0003);
        add_op(OP_PEEK_REAR, 32'h0);
        add_op(OP_POP_FRONT, 32'h0);
        add_op(OP_POP_REAR, 32'h0);
        wait_idle();

        // Random phases. Zero acts as one entry and 255 saturates to the
        // depth. Phases can end with entries still held, so each capacity write
        // also checks that the deque is emptied.
        set_capacity(8'd0);
        add_random(30);
        wait_idle();

        set_capacity(8'd2);
        add_random(40);
        wait_idle();

        set_capacity(8'd5);
        add_random(50);
        wait_idle();

        // Full depth, with the receiver holding off for a long stretch while
        // items keep coming, so the block backs up and stalls its input.
        set_capacity(8'hFF);
        add_random(170);
        long_hold_req = 1'b1;
        wait_idle();

        // Midway through this phase the sender stops until every result is
        // back, then resumes.
        set_capacity(8'd17);
        add_random(60);
        while (op_backlog.size() > 30)
            @(negedge clk);
        sender_hold = 1'b1;
        while (in_valid || accepted_count != checked_count)
            @(negedge clk);
        repeat ($urandom_range(3, 10)) @(negedge clk);
        sender_hold = 1'b0;
        wait_idle();

        set_capacity(8'($urandom_range(3, 127)));
        add_random(40);
        wait_idle();

        set_capacity(8'd128);
        add_random(40);
        wait_idle();

        repeat (8) @(negedge clk);
        @(posedge clk);
        $display("Checked %0d operations over %0d capacity settings:", accepted_count,
                 n_settings);
        $display("%0d overflows, %0d underflows, %0d full results, %0d stalled cycles.",
                 n_overflow, n_underflow, n_full, backpressure_cycles);
        if (error_count == 0)
            $display("PASS circular_deque");
        else
            $display("FAIL circular_deque");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_mem.sv
hdl/cdq_ptr.sv
hdl/circular_deque.sv
verif/tb.sv
